// File: rtl/core/json_string_unescape_utf8_unit_assert.svh
// ---------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shared concurrent assertion forms for the unescape unit.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// same-cycle implication
`define JSU_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg
// Result kinds, error codes and the queue entry shared by the unescape unit.
// ---------------------------------------------------------------------------
package jsu_pkg;

    localparam int CP_W = 21;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
    localparam logic [2:0] ERR_CTRL      = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_HEX       = 3'd3;
    localparam logic [2:0] ERR_NO_LOW    = 3'd4;
    localparam logic [2:0] ERR_BAD_LOW   = 3'd5;
    localparam logic [2:0] ERR_LONE_LOW  = 3'd6;
    localparam logic [2:0] ERR_EARLY_END = 3'd7;

    // raw: pass the low byte of cp through as is, no UTF-8 encoding
    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      code;
        logic            raw;
        logic [CP_W-1:0] cp;
    } entry_t;

endpackage

// File: rtl/core/jsu_front.sv
// ---------------------------------------------------------------------------
// jsu_front
// Parse literal bytes, track escapes and surrogates, queue one entry per
// byte that produces output (a code point, an end or an error).
// ---------------------------------------------------------------------------
module jsu_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              starts,
    input  logic              ends_input,
    output logic              push,
    output jsu_pkg::entry_t   entry
);

    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_BODY     = 3'd1;
    localparam logic [2:0] MODE_ESC      = 3'd2;
    localparam logic [2:0] MODE_HEX_HIGH = 3'd3;
    localparam logic [2:0] MODE_WANT_BS  = 3'd4;
    localparam logic [2:0] MODE_WANT_U   = 3'd5;
    localparam logic [2:0] MODE_HEX_LOW  = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [15:0] HIGH_MIN = 16'hd800;
    localparam logic [15:0] HIGH_MAX = 16'hdbff;
    localparam logic [15:0] LOW_MIN  = 16'hdc00;
    localparam logic [15:0] LOW_MAX  = 16'hdfff;
    localparam logic [jsu_pkg::CP_W-1:0] SUPP_BASE = 21'h10000;

    logic [2:0]  mode_reg,  mode_next;
    logic [15:0] high_reg,  high_next;
    logic [15:0] low_reg,   low_next;
    logic [1:0]  digit_reg, digit_next;

    logic        nib_ok;
    logic [3:0]  nib;
    logic [15:0] high_shift;
    logic [15:0] low_shift;

    always_comb begin
        nib_ok = 1'b1;
        nib    = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            nib = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            nib = in_byte[3:0] + 4'd9;
        end else begin
            nib_ok = 1'b0;
        end
    end

    assign high_shift = {high_reg[11:0], nib};
    assign low_shift  = {low_reg[11:0], nib};

    always_comb begin
        mode_next  = mode_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        digit_next = digit_reg;
        push       = 1'b0;
        entry.kind = jsu_pkg::KIND_DATA;
        entry.code = jsu_pkg::ERR_NO_QUOTE;
        entry.raw  = 1'b0;
        entry.cp   = '0;
        if (accept) begin
            priority if (starts) begin
                digit_next = 2'd0;
                if (ends_input) begin
                    push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                    entry.code = jsu_pkg::ERR_EARLY_END; mode_next = MODE_IDLE;
                end else if (in_byte != CH_QUOTE) begin
                    push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                    entry.code = jsu_pkg::ERR_NO_QUOTE; mode_next = MODE_IDLE;
                end else begin
                    mode_next = MODE_BODY;
                end
            end else if (mode_reg == MODE_IDLE) begin
                mode_next = MODE_IDLE;
            end else if (ends_input) begin
                push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                entry.code = jsu_pkg::ERR_EARLY_END;
                mode_next = MODE_IDLE; digit_next = 2'd0;
            end else begin
                unique case (mode_reg)
                    MODE_BODY: begin
                        priority if (in_byte == CH_QUOTE) begin
                            push = 1'b1; entry.kind = jsu_pkg::KIND_END;
                            mode_next = MODE_IDLE;
                        end else if (in_byte < CH_SPACE) begin
                            push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                            entry.code = jsu_pkg::ERR_CTRL;
                            mode_next = MODE_IDLE; digit_next = 2'd0;
                        end else if (in_byte == CH_BSLASH) begin
                            mode_next = MODE_ESC;
                        end else begin
                            push = 1'b1; entry.raw = 1'b1;
                            entry.cp = {13'd0, in_byte};
                        end
                    end
                    MODE_ESC: begin
                        push      = 1'b1;
                        mode_next = MODE_BODY;
                        unique case (in_byte)
                            CH_QUOTE:  entry.cp = {13'd0, CH_QUOTE};
                            CH_BSLASH: entry.cp = {13'd0, CH_BSLASH};
                            CH_SLASH:  entry.cp = {13'd0, CH_SLASH};
                            CH_B:      entry.cp = 21'h08;
                            CH_F:      entry.cp = 21'h0c;
                            CH_N:      entry.cp = 21'h0a;
                            CH_R:      entry.cp = 21'h0d;
                            CH_T:      entry.cp = 21'h09;
                            CH_U: begin
                                push = 1'b0; mode_next = MODE_HEX_HIGH;
                                high_next = 16'd0; digit_next = 2'd0;
                            end
                            default: begin
                                entry.kind = jsu_pkg::KIND_ERR;
                                entry.code = jsu_pkg::ERR_ESCAPE;
                                mode_next = MODE_IDLE; digit_next = 2'd0;
                            end
                        endcase
                    end
                    MODE_HEX_HIGH: begin
                        priority if (!nib_ok) begin
                            push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                            entry.code = jsu_pkg::ERR_HEX;
                            mode_next = MODE_IDLE; digit_next = 2'd0;
                        end else if (digit_reg != 2'd3) begin
                            high_next  = high_shift;
                            digit_next = digit_reg + 2'd1;
                        end else begin
                            high_next  = high_shift;
                            digit_next = 2'd0;
                            priority if (high_shift >= HIGH_MIN && high_shift <= HIGH_MAX) begin
                                mode_next = MODE_WANT_BS;
                            end else if (high_shift >= LOW_MIN && high_shift <= LOW_MAX) begin
                                push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                                entry.code = jsu_pkg::ERR_LONE_LOW;
                                mode_next = MODE_IDLE;
                            end else begin
                                push = 1'b1; entry.cp = {5'd0, high_shift};
                                mode_next = MODE_BODY;
                            end
                        end
                    end
                    MODE_WANT_BS: begin
                        if (in_byte != CH_BSLASH) begin
                            push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                            entry.code = jsu_pkg::ERR_NO_LOW;
                            mode_next = MODE_IDLE; digit_next = 2'd0;
                        end else begin
                            mode_next = MODE_WANT_U;
                        end
                    end
                    MODE_WANT_U: begin
                        if (in_byte != CH_U) begin
                            push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                            entry.code = jsu_pkg::ERR_NO_LOW;
                            mode_next = MODE_IDLE; digit_next = 2'd0;
                        end else begin
                            mode_next = MODE_HEX_LOW;
                            low_next = 16'd0; digit_next = 2'd0;
                        end
                    end
                    MODE_HEX_LOW: begin
                        priority if (!nib_ok) begin
                            push = 1'b1; entry.kind = jsu_pkg::KIND_ERR;
                            entry.code = jsu_pkg::ERR_HEX;
                            mode_next = MODE_IDLE; digit_next = 2'd0;
                        end else if (digit_reg != 2'd3) begin
                            low_next   = low_shift;
                            digit_next = digit_reg + 2'd1;
                        end else begin
                            low_next   = low_shift;
                            digit_next = 2'd0;
                            push       = 1'b1;
                            if (low_shift < LOW_MIN || low_shift > LOW_MAX) begin
                                entry.kind = jsu_pkg::KIND_ERR;
                                entry.code = jsu_pkg::ERR_BAD_LOW;
                                mode_next  = MODE_IDLE;
                            end else begin
                                entry.cp  = SUPP_BASE +
                                            {1'b0, high_reg[9:0], low_shift[9:0]};
                                mode_next = MODE_BODY;
                            end
                        end
                    end
                    default: begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            high_reg  <= 16'd0;
            low_reg   <= 16'd0;
            digit_reg <= 2'd0;
        end else begin
            mode_reg  <= mode_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// File: rtl/core/jsu_queue.sv
// ---------------------------------------------------------------------------
// jsu_queue
// Small register FIFO that decouples the parser from the UTF-8 serializer.
// ---------------------------------------------------------------------------
`include "json_string_unescape_utf8_unit_assert.svh"

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  jsu_pkg::entry_t  push_entry,
    input  logic             pop,
    output jsu_pkg::entry_t  head,
    output logic             empty,
    output logic             full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::entry_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign empty = (count_reg == CW'(0));
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `JSU_ASSERT_SAME(a_no_overflow, aclk, aresetn, push, !full, "queue push while full")
    `JSU_ASSERT_SAME(a_no_underflow, aclk, aresetn, pop, !empty, "queue pop while empty")
    `JSU_ASSERT_NEXT(a_fill_to_full, aclk, aresetn, push && !pop && count_reg == CW'(DEPTH - 1), full, "queue did not report full")

endmodule

// File: rtl/core/jsu_back.sv
// ---------------------------------------------------------------------------
// jsu_back
// Expand each queued entry into its UTF-8 bytes (a raw byte as is), or one end or error
// result, through a registered output stage.
// ---------------------------------------------------------------------------
`include "json_string_unescape_utf8_unit_assert.svh"

module jsu_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  jsu_pkg::entry_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic [4:0]       m_tuser,
    output logic             m_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic [1:0] last_idx;
    logic       load;
    logic [7:0] sel_byte;
    logic [7:0] utf [4];

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic [4:0] user_reg;
    logic       last_reg;

    always_comb begin
        utf[0] = 8'd0;
        utf[1] = 8'd0;
        utf[2] = 8'd0;
        utf[3] = 8'd0;
        priority if (head.kind != jsu_pkg::KIND_DATA) begin
            last_idx = 2'd0;
        end else if (head.raw || head.cp <= 21'h7f) begin
            last_idx = 2'd0;
            utf[0]   = head.cp[7:0];
        end else if (head.cp <= 21'h7ff) begin
            last_idx = 2'd1;
            utf[0]   = {3'b110, head.cp[10:6]};
            utf[1]   = {2'b10, head.cp[5:0]};
        end else if (head.cp <= 21'hffff) begin
            last_idx = 2'd2;
            utf[0]   = {4'b1110, head.cp[15:12]};
            utf[1]   = {2'b10, head.cp[11:6]};
            utf[2]   = {2'b10, head.cp[5:0]};
        end else begin
            last_idx = 2'd3;
            utf[0]   = {5'b11110, head.cp[20:18]};
            utf[1]   = {2'b10, head.cp[17:12]};
            utf[2]   = {2'b10, head.cp[11:6]};
            utf[3]   = {2'b10, head.cp[5:0]};
        end
        sel_byte = utf[idx_reg];
    end

    assign load = !empty && (!valid_reg || m_tready);
    assign pop  = load && (idx_reg == last_idx);

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = pop ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= sel_byte;
            user_reg <= {(head.kind == jsu_pkg::KIND_ERR) ? head.code : 3'd0, head.kind};
            last_reg <= (idx_reg == last_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    `JSU_ASSERT_SAME(a_nondata_last, aclk, aresetn, valid_reg && user_reg[1:0] != jsu_pkg::KIND_DATA, last_reg, "end or error result not marked last")
    `JSU_ASSERT_SAME(a_data_no_code, aclk, aresetn, valid_reg && user_reg[1:0] == jsu_pkg::KIND_DATA, user_reg[4:2] == 3'd0 && user_reg[1:0] == jsu_pkg::KIND_DATA, "data result carries error code")
    `JSU_ASSERT_SAME(a_idx_in_range, aclk, aresetn, !empty, idx_reg <= last_idx, "byte index past code point length")

endmodule

// File: rtl/core/json_string_unescape_utf8_unit.sv
// The parser queues each result, and the registered output stage presents it on m_tvalid.
// Throughput: one input byte per cycle while the queue is not full; a code point of n UTF-8
//   bytes holds the output for all n bytes, which the entry queue absorbs.
// The input stalls only when the QUEUE_DEPTH-entry queue between parser and serializer is full.
// Reset: aresetn low clears parser state to idle, empties the queue and drops m_tvalid.
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// JSON string literal unescaper: parser front, entry queue, UTF-8 back end.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [1:0] s_tuser,   // [0] starts, [1] ends_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [4:0] m_tuser,   // [1:0] kind, [4:2] error_code
    output logic       m_tlast
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;
    jsu_pkg::entry_t push_entry;
    jsu_pkg::entry_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    jsu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_byte    (s_tdata),
        .starts     (s_tuser[0]),
        .ends_input (s_tuser[1]),
        .push       (push),
        .entry      (push_entry)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: bench/json_string_unescape_utf8_unit_tb.sv
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_unit_tb
// Feeds JSON string literals byte by byte into the unescape unit and checks
// every decoded byte, end marker and error item against a cycle-free model
// of the unescaper. Stimulus is a short directed run of corner cases followed
// by random literals, well-formed for the most part, with broken tails and
// noise mixed in. Both stream sides idle at random; one long output stall
// forces the unit to back up and stall its input.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 450;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U = 8'h75;

    typedef enum logic [2:0] {
        P_IDLE, P_BODY, P_ESC, P_HEX_HI, P_WANT_BS, P_WANT_U, P_HEX_LO
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] b;
        logic       st;
        logic       en;
    } raw_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
        logic       last;
    } decoded_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic [1:0] s_tuser = 2'b00;   // [0] starts, [1] ends_input
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic [4:0] m_tuser;           // [1:0] kind, [4:2] error_code
    logic       m_tlast;

    json_string_unescape_utf8_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    raw_byte_t   literal_bytes_q[$];
    decoded_t    decoded_q[$];
    parse_mode_t p_mode = P_IDLE;
    logic [15:0] p_high = '0;
    logic [15:0] p_low = '0;
    logic [1:0]  p_digits = '0;

    int planned = 0;
    int cycle_count = 0;
    int bytes_accepted = 0;
    int results_seen = 0;
    int errors_seen = 0;
    int closes_seen = 0;
    int multibyte_chars = 0;
    int mismatches = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_stretch = 0;
    int rx_style = 0;
    int hold_left = 0;
    bit hold_done = 0;
    bit open_literal = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------- model ----------------

    function automatic int hex_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - 48;
        if (b >= "a" && b <= "f") return int'(b) - 87;
        if (b >= "A" && b <= "F") return int'(b) - 55;
        return -1;
    endfunction

    function automatic void emit(input logic [7:0] data, input logic [1:0] kind,
                                 input logic [2:0] code, input logic last);
        decoded_t r;
        r.data = data;
        r.kind = kind;
        r.code = code;
        r.last = last;
        decoded_q.insert(decoded_q.size(), r);
    endfunction

    function automatic void fault(input logic [2:0] code);
        p_mode = P_IDLE;
        p_digits = '0;
        emit(8'h00, jsu_pkg::KIND_ERR, code, 1'b1);
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        p_mode = P_BODY;
        if (cp <= 21'h7f) begin
            emit(cp[7:0], jsu_pkg::KIND_DATA, 3'd0, 1'b1);
        end else if (cp <= 21'h7ff) begin
            emit({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, 3'd0, 1'b0);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, 3'd0, 1'b1);
        end else if (cp <= 21'hffff) begin
            emit({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, 3'd0, 1'b0);
            emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, 3'd0, 1'b0);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, 3'd0, 1'b1);
        end else begin
            emit({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, 3'd0, 1'b0);
            emit({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, 3'd0, 1'b0);
            emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, 3'd0, 1'b0);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, 3'd0, 1'b1);
        end
        if (cp > 21'h7f) multibyte_chars++;
    endfunction

    function automatic void unescape_byte(input logic [7:0] b, input logic st,
                                          input logic en);
        int d;
        d = hex_value(b);
        if (st) begin
            if (en) fault(jsu_pkg::ERR_EARLY_END);
            else if (b != CH_QUOTE) fault(jsu_pkg::ERR_NO_QUOTE);
            else begin
                p_mode = P_BODY;
                p_digits = '0;
            end
            return;
        end
        if (p_mode == P_IDLE) return;
        if (en) begin
            fault(jsu_pkg::ERR_EARLY_END);
            return;
        end
        case (p_mode)
            P_BODY: begin
                if (b == CH_QUOTE) begin
                    p_mode = P_IDLE;
                    emit(8'h00, jsu_pkg::KIND_END, 3'd0, 1'b1);
                end else if (b < 8'h20) begin
                    fault(jsu_pkg::ERR_CTRL);
                end else if (b == CH_BSLASH) begin
                    p_mode = P_ESC;
                end else begin
                    emit(b, jsu_pkg::KIND_DATA, 3'd0, 1'b1);
                end
            end
            P_ESC: begin
                case (b)
                    8'h22, 8'h5c, 8'h2f: emit_code_point({13'd0, b});
                    8'h62: emit_code_point(21'h08);
                    8'h66: emit_code_point(21'h0c);
                    8'h6e: emit_code_point(21'h0a);
                    8'h72: emit_code_point(21'h0d);
                    8'h74: emit_code_point(21'h09);
                    CH_U: begin
                        p_mode = P_HEX_HI;
                        p_high = '0;
                        p_digits = '0;
                    end
                    default: fault(jsu_pkg::ERR_ESCAPE);
                endcase
            end
            P_HEX_HI: begin
                if (d < 0) begin
                    fault(jsu_pkg::ERR_HEX);
                end else begin
                    p_high = {p_high[11:0], d[3:0]};
                    if (p_digits < 2'd3) begin
                        p_digits++;
                    end else begin
                        p_digits = '0;
                        if (p_high >= 16'hd800 && p_high <= 16'hdbff)
                            p_mode = P_WANT_BS;
                        else if (p_high >= 16'hdc00 && p_high <= 16'hdfff)
                            fault(jsu_pkg::ERR_LONE_LOW);
                        else
                            emit_code_point({5'd0, p_high});
                    end
                end
            end
            P_WANT_BS: begin
                if (b != CH_BSLASH) fault(jsu_pkg::ERR_NO_LOW);
                else p_mode = P_WANT_U;
            end
            P_WANT_U: begin
                if (b != CH_U) begin
                    fault(jsu_pkg::ERR_NO_LOW);
                end else begin
                    p_mode = P_HEX_LO;
                    p_low = '0;
                    p_digits = '0;
                end
            end
            P_HEX_LO: begin
                if (d < 0) begin
                    fault(jsu_pkg::ERR_HEX);
                end else begin
                    p_low = {p_low[11:0], d[3:0]};
                    if (p_digits < 2'd3) begin
                        p_digits++;
                    end else begin
                        p_digits = '0;
                        if (p_low < 16'hdc00 || p_low > 16'hdfff)
                            fault(jsu_pkg::ERR_BAD_LOW);
                        else emit_code_point(21'h10000 + (21'(p_high - 16'hd800) << 10)
                                             + 21'(p_low - 16'hdc00));
                    end
                end
            end
            default: p_mode = P_IDLE;
        endcase
    endfunction

    // ---------------- stimulus ----------------

    task automatic add_item(input logic [7:0] b, input bit st, input bit en, input bit counted);
        raw_byte_t it;
        it.b = b;
        it.st = st;
        it.en = en;
        literal_bytes_q.insert(literal_bytes_q.size(), it);
        if (counted) planned++;
    endtask

    task automatic add_hex_unit(input logic [15:0] u);
        logic [3:0] nib;
        for (int i = 3; i >= 0; i--) begin
            nib = u[i*4 +: 4];
            if (nib < 10) add_item(8'h30 + nib, 0, 0, 1);
            else if ($urandom_range(0, 1)) add_item(8'h57 + nib, 0, 0, 1);
            else add_item(8'h37 + nib, 0, 0, 1);
        end
    endtask

    task automatic add_bmp_unit();
        logic [15:0] u;
        case ($urandom_range(0, 3))
            0: u = 16'($urandom_range(0, 16'h7f));
            1: u = 16'($urandom_range(16'h80, 16'h7ff));
            2: u = 16'($urandom_range(16'h800, 16'hd7ff));
            default: u = 16'($urandom_range(16'he000, 16'hffff));
        endcase
        add_item(CH_BSLASH, 0, 0, 1);
        add_item(CH_U, 0, 0, 1);
        add_hex_unit(u);
    endtask

    task automatic add_high_surrogate();
        add_item(CH_BSLASH, 0, 0, 1);
        add_item(CH_U, 0, 0, 1);
        add_hex_unit(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
    endtask

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
        return b;
    endfunction

    task automatic add_element();
        logic [7:0] b;
        logic [7:0] esc_chars[8];
        esc_chars = '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                do b = 8'($urandom_range(8'h20, 8'hff));
                while (b == CH_QUOTE || b == CH_BSLASH);
                add_item(b, 0, 0, 1);
            end
            4, 5: begin
                add_item(CH_BSLASH, 0, 0, 1);
                add_item(esc_chars[$urandom_range(0, 7)], 0, 0, 1);
            end
            6, 7: add_bmp_unit();
            default: begin
                add_high_surrogate();
                add_item(CH_BSLASH, 0, 0, 1);
                add_item(CH_U, 0, 0, 1);
                add_hex_unit(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
            end
        endcase
    endtask

    task automatic add_broken_tail();
        logic [7:0] b;
        logic [15:0] u;
        case ($urandom_range(0, 10))
            0: add_item(8'($urandom_range(0, 8'h1f)), 0, 0, 1);
            1: begin
                add_item(CH_BSLASH, 0, 0, 1);
                do b = 8'($urandom_range(0, 255));
                while (b inside {8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74, CH_U});
                add_item(b, 0, 0, 1);
            end
            2: begin
                add_item(CH_BSLASH, 0, 0, 1);
                add_item(CH_U, 0, 0, 1);
                repeat ($urandom_range(0, 3)) add_item("7", 0, 0, 1);
                add_item(bad_hex_char(), 0, 0, 1);
            end
            3: begin
                add_high_surrogate();
                do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
                add_item(b, 0, 0, 1);
            end
            4: begin
                add_high_surrogate();
                add_item(CH_BSLASH, 0, 0, 1);
                do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                add_item(b, 0, 0, 1);
            end
            5: begin
                add_high_surrogate();
                add_item(CH_BSLASH, 0, 0, 1);
                add_item(CH_U, 0, 0, 1);
                do u = 16'($urandom_range(0, 16'hffff));
                while (u >= 16'hdc00 && u <= 16'hdfff);
                add_hex_unit(u);
            end
            6: begin
                add_item(CH_BSLASH, 0, 0, 1);
                add_item(CH_U, 0, 0, 1);
                add_hex_unit(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
            end
            7: begin
                case ($urandom_range(0, 2))
                    0: add_item(CH_BSLASH, 0, 0, 1);
                    1: begin
                        add_item(CH_BSLASH, 0, 0, 1);
                        add_item(CH_U, 0, 0, 1);
                        add_item("a", 0, 0, 1);
                    end
                    default: add_high_surrogate();
                endcase
                add_item(8'($urandom_range(0, 255)), 0, 1, 1);
            end
            8: add_item(8'($urandom_range(0, 255)), 1, 1, 1);
            9: begin
                add_high_surrogate();
                add_item(CH_BSLASH, 0, 0, 1);
                add_item(CH_U, 0, 0, 1);
                add_item("D", 0, 0, 1);
                add_item(bad_hex_char(), 0, 0, 1);
            end
            default: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                add_item(b, 1, 0, 1);
            end
        endcase
    endtask

    task automatic build_stimulus();
        // directed corner cases
        add_item("x", 0, 0, 0);
        add_item(8'hff, 0, 1, 0);
        add_item(8'h00, 1, 1, 1);
        add_item(8'h00, 1, 0, 1);
        add_item(CH_QUOTE, 1, 0, 1);
        add_item(8'hff, 0, 0, 1);
        add_item(8'h7f, 0, 0, 1);
        add_item(8'h20, 0, 0, 1);
        add_item(8'h1f, 0, 0, 1);
        add_item(CH_QUOTE, 1, 0, 1);
        add_item(CH_BSLASH, 0, 0, 1);
        add_item("n", 0, 0, 1);
        add_item(CH_QUOTE, 1, 0, 1);
        add_item(CH_BSLASH, 0, 0, 1);
        add_item(CH_U, 0, 0, 1);
        add_hex_unit(16'hd800);
        add_item("a", 0, 0, 1);
        add_item(CH_QUOTE, 1, 0, 1);
        add_item(8'h41, 0, 1, 1);
        add_item(CH_QUOTE, 1, 0, 1);
        add_item(CH_QUOTE, 0, 0, 1);

        // random literals
        planned = 0;
        open_literal = 0;
        while (planned < RANDOM_BYTES) begin
            if (!open_literal && $urandom_range(0, 9) == 0)
                add_item(8'($urandom_range(0, 255)), 0, 1'($urandom_range(0, 1)), 0);
            add_item(CH_QUOTE, 1, 0, 1);
            repeat ($urandom_range(0, 10)) add_element();
            case ($urandom_range(0, 99)) inside
                [0:69]: begin
                    add_item(CH_QUOTE, 0, 0, 1);
                    open_literal = 0;
                end
                [70:77]: open_literal = 1;
                default: begin
                    add_broken_tail();
                    open_literal = 0;
                end
            endcase
        end
        if (open_literal) add_item(CH_QUOTE, 0, 0, 1);
    endtask

    // ---------------- checking ----------------

    function automatic void report(input string what, input decoded_t want);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch @%0d %s: want data=%02h kind=%0d code=%0d last=%0b",
                     cycle_count, what, want.data, want.kind, want.code, want.last);
            $display("    got data=%02h kind=%0d code=%0d last=%0b",
                     m_tdata, m_tuser[1:0], m_tuser[4:2], m_tlast);
        end
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                unescape_byte(s_tdata, s_tuser[0], s_tuser[1]);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (literal_bytes_q.size() > 0) begin
                    s_tdata <= literal_bytes_q[0].b;
                    s_tuser <= {literal_bytes_q[0].en, literal_bytes_q[0].st};
                    void'(literal_bytes_q.pop_front());
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 4) == 0) begin
                            burst_left = $urandom_range(40, 100);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left = $urandom_range(0, 6);
                        end
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall style changes per stretch, plus one long hold-off
    always @(posedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && bytes_accepted >= 150) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (rx_stretch == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_stretch = $urandom_range(20, 150);
            end
            rx_stretch--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rx_style)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (rx_stretch % 4 == 0);
                    default: rdy = ($urandom_range(0, 9) != 0);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // monitor
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[1:0] == jsu_pkg::KIND_ERR) errors_seen++;
            if (m_tuser[1:0] == jsu_pkg::KIND_END) closes_seen++;
            if (decoded_q.size() == 0) begin
                report("item with nothing pending", '0);
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.data) report("out_byte", want);
                else if (m_tuser[1:0] !== want.kind) report("kind", want);
                else if (m_tuser[4:2] !== want.code) report("error_code", want);
                else if (m_tlast !== want.last) report("last", want);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d items pending", decoded_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (literal_bytes_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (decoded_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d bytes in, %0d items out: %0d closed strings, %0d errors",
                 bytes_accepted, results_seen, closes_seen, errors_seen);
        $display("%0d multi-byte characters, %0d mismatches", multibyte_chars, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
